>>> rtl/lrv_pkg.sv
package lrv_pkg;

    // length fields are taken at this many bits
    localparam int LEN_BITS = 32;
    localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LEN_BITS);

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int HSZ_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SEVERITY    = 3'd0,
        REG_ALLOWED_FLAGS   = 3'd1,
        REG_MAX_MESSAGE_LEN = 3'd2,
        REG_MAX_FIELDS_LEN  = 3'd3,
        REG_HEADER_SIZE     = 3'd4
    } cfg_idx_t;

    localparam logic [31:0]      RST_MAX_SEVERITY    = 32'd7;
    localparam logic [31:0]      RST_ALLOWED_FLAGS   = 32'd0;
    localparam logic [31:0]      RST_MAX_MESSAGE_LEN = 32'd1024;
    localparam logic [31:0]      RST_MAX_FIELDS_LEN  = 32'd4096;
    localparam logic [HSZ_W-1:0] RST_HEADER_SIZE     = 8'd24;

    typedef enum logic {
        OP_HEADER  = 1'b0,
        OP_PAYLOAD = 1'b1
    } op_t;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    typedef struct packed {
        logic [31:0]      max_severity;
        logic [31:0]      allowed_flag_mask;
        logic [31:0]      max_msg_len;
        logic [31:0]      max_fld_len;
        logic [HSZ_W-1:0] header_size;
    } cfg_t;

    // one item as held in the input register
    typedef struct packed {
        op_t                 opcode;
        logic                hdr_bad;
        logic [LEN_BITS-1:0] msg_len;
        logic [LEN_BITS-1:0] fld_len;
        logic [7:0]          data_byte;
        logic                last;
    } item_t;

endpackage

>>> rtl/lrv_hdr_check.sv
module lrv_hdr_check
(
    input  lrv_pkg::cfg_t cfg,
    input  logic [31:0]   severity,
    input  logic [31:0]   record_flags,
    input  logic [31:0]   msg_length,
    input  logic [31:0]   fld_length,
    input  logic [31:0]   record_length,
    output logic          hdr_bad
);

    logic [31:0] mlen;
    logic [31:0] flen;
    logic [31:0] rlen;
    logic [31:0] hsz;
    logic [32:0] sect_sum;
    logic [31:0] body_len;

    assign mlen     = msg_length & lrv_pkg::LEN_MASK;
    assign flen     = fld_length & lrv_pkg::LEN_MASK;
    assign rlen     = record_length & lrv_pkg::LEN_MASK;
    assign hsz      = {{(32 - lrv_pkg::HSZ_W){1'b0}}, cfg.header_size};
    assign sect_sum = {1'b0, mlen} + {1'b0, flen};
    assign body_len = rlen - hsz;

    // a short record fails on its own, so the body length only matters when it holds
    assign hdr_bad = (rlen < hsz)
                  || (severity > cfg.max_severity)
                  || ((record_flags & ~cfg.allowed_flag_mask) != 32'd0)
                  || (mlen == 32'd0)
                  || (mlen > cfg.max_msg_len)
                  || (flen > cfg.max_fld_len)
                  || (sect_sum != {1'b0, body_len});

endmodule

>>> rtl/lrv_core.sv
module lrv_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  lrv_pkg::item_t item,
    output logic           verdict_valid,
    output logic           verdict_accept
);

    logic                         failed_reg,  failed_next;
    logic [lrv_pkg::LEN_BITS-1:0] msg_left_reg, msg_left_next;
    logic [lrv_pkg::LEN_BITS-1:0] fld_left_reg, fld_left_next;
    logic                         present_reg, present_next;
    logic                         at_ls_reg,   at_ls_next;
    logic                         eq_seen_reg, eq_seen_next;
    logic                         eq_at_ls_reg, eq_at_ls_next;
    logic                         ls_us_reg,   ls_us_next;

    logic [7:0] c;
    logic       eq_seen_w;
    logic       eq_at_ls_w;
    logic       ls_us_w;
    logic       upper;
    logic       tail;
    logic       line_bad_w;
    logic       ok;

    assign c = item.data_byte;

    always_comb
    begin
        failed_next   = failed_reg;
        msg_left_next = msg_left_reg;
        fld_left_next = fld_left_reg;
        present_next  = present_reg;
        at_ls_next    = at_ls_reg;
        eq_seen_next  = eq_seen_reg;
        eq_at_ls_next = eq_at_ls_reg;
        ls_us_next    = ls_us_reg;

        upper      = (c >= lrv_pkg::CH_UPPER_A) && (c <= lrv_pkg::CH_UPPER_Z);
        tail       = ((c >= lrv_pkg::CH_DIGIT_0) && (c <= lrv_pkg::CH_DIGIT_9))
                  || (c == lrv_pkg::CH_UNDER);
        eq_seen_w  = eq_seen_reg;
        eq_at_ls_w = eq_at_ls_reg;
        if ((c == lrv_pkg::CH_EQUALS) && !eq_seen_reg)
        begin
            eq_seen_w  = 1'b1;
            eq_at_ls_w = at_ls_reg;
        end
        ls_us_w    = at_ls_reg ? (c == lrv_pkg::CH_UNDER) : ls_us_reg;
        line_bad_w = at_ls_reg || !eq_seen_w || eq_at_ls_w || ls_us_w;

        if (item.opcode == lrv_pkg::OP_HEADER)
        begin
            // a header always starts a fresh record
            failed_next   = item.hdr_bad;
            msg_left_next = item.msg_len;
            fld_left_next = item.fld_len;
            present_next  = (item.fld_len != '0);
            at_ls_next    = 1'b1;
            eq_seen_next  = 1'b0;
            eq_at_ls_next = 1'b0;
            ls_us_next    = 1'b0;
        end
        else if (msg_left_reg != '0)
        begin
            msg_left_next = msg_left_reg - 1'b1;
            if ((c < lrv_pkg::CH_SPACE) || (c == lrv_pkg::CH_DEL))
                failed_next = 1'b1;
        end
        else if (fld_left_reg != '0)
        begin
            fld_left_next = fld_left_reg - 1'b1;
            if ((c == lrv_pkg::CH_NUL) || (c == lrv_pkg::CH_DEL)
                || ((c < lrv_pkg::CH_SPACE) && (c != lrv_pkg::CH_NEWLINE)))
            begin
                failed_next = 1'b1;
            end
            else if (!eq_seen_w && !(upper || (!at_ls_reg && tail)))
            begin
                // bad key character, line state left as it was
                failed_next = 1'b1;
            end
            else if (c == lrv_pkg::CH_NEWLINE)
            begin
                if (line_bad_w)
                    failed_next = 1'b1;
                at_ls_next    = 1'b1;
                eq_seen_next  = 1'b0;
                eq_at_ls_next = 1'b0;
                ls_us_next    = 1'b0;
            end
            else
            begin
                at_ls_next    = 1'b0;
                eq_seen_next  = eq_seen_w;
                eq_at_ls_next = eq_at_ls_w;
                ls_us_next    = ls_us_w;
            end
        end
        else
        begin
            // byte beyond the declared lengths
            failed_next = 1'b1;
        end

        ok = !failed_next && (msg_left_next == '0) && (fld_left_next == '0)
          && !(present_next
               && (at_ls_next || !eq_seen_next || eq_at_ls_next || ls_us_next));

        // verdict clears the record
        if (item.last)
        begin
            failed_next   = 1'b0;
            msg_left_next = '0;
            fld_left_next = '0;
            present_next  = 1'b0;
            at_ls_next    = 1'b1;
            eq_seen_next  = 1'b0;
            eq_at_ls_next = 1'b0;
            ls_us_next    = 1'b0;
        end
    end

    assign verdict_valid  = fire && item.last;
    assign verdict_accept = ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg   <= 1'b0;
            msg_left_reg <= '0;
            fld_left_reg <= '0;
            present_reg  <= 1'b0;
            at_ls_reg    <= 1'b1;
            eq_seen_reg  <= 1'b0;
            eq_at_ls_reg <= 1'b0;
            ls_us_reg    <= 1'b0;
        end
        else if (fire)
        begin
            failed_reg   <= failed_next;
            msg_left_reg <= msg_left_next;
            fld_left_reg <= fld_left_next;
            present_reg  <= present_next;
            at_ls_reg    <= at_ls_next;
            eq_seen_reg  <= eq_seen_next;
            eq_at_ls_reg <= eq_at_ls_next;
            ls_us_reg    <= ls_us_next;
        end
    end

endmodule

>>> rtl/log_record_validator.sv
// log record validator
// input stream (s_axis): one transfer per item. tuser is the opcode (header
// or payload byte), tlast marks the final item of a record. a header
// transfer carries severity, flags and the three lengths in tdata; a
// payload transfer carries one byte in the top byte lane of tdata
// output stream (m_axis): one transfer per record, taken on the item marked
// last; tdata bit 0 is the verdict (1 accept, 0 reject), upper bits zero
// configuration: cfg_we/cfg_index/cfg_data write one limit register per
// cycle; the user must write only while no record is in flight (unenforced)
// path: a transfer is captured in the input register (header limits are
// checked on the way in); from there it passes the byte checker and the
// record state, and a verdict lands in the output register, which drives
// m_axis_tvalid
// throughput: one item per cycle unless a last item is held (see stall),
// set by the single pass through the byte checker and its state registers
// stall: while a verdict waits in the output register, items without tlast
// still flow; an item with tlast holds in the input register and s_axis
// backs up behind it
// reset: limits return to their defaults, record state is cleared and both
// streams are empty
module log_record_validator
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // severity[31:0], record_flags[63:32], msg_len[95:64],
    // fld_len[127:96], record_length[159:128], data_byte[167:160]
    input  logic [167:0]                    s_axis_tdata,
    // opcode[0]
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accept[0], zero fill[7:1]
    output logic [7:0]                      m_axis_tdata,

    input  logic                            cfg_we,
    input  logic [lrv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lrv_pkg::CFG_W-1:0]       cfg_data
);

    // limit registers
    lrv_pkg::cfg_t  cfg_reg;

    // input register
    logic           in_valid_reg;
    lrv_pkg::item_t item_reg;
    lrv_pkg::item_t item_next;
    logic           hdr_bad;

    // output register
    logic           out_valid_reg;
    logic           accept_reg;

    logic           s_fire;
    logic           advance;
    logic           verdict_valid;
    logic           verdict_accept;

    // a last item moves on only if the output register is free or draining
    assign advance       = in_valid_reg
                        && (!item_reg.last || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_severity      <= lrv_pkg::RST_MAX_SEVERITY;
            cfg_reg.allowed_flag_mask <= lrv_pkg::RST_ALLOWED_FLAGS;
            cfg_reg.max_msg_len       <= lrv_pkg::RST_MAX_MESSAGE_LEN;
            cfg_reg.max_fld_len       <= lrv_pkg::RST_MAX_FIELDS_LEN;
            cfg_reg.header_size       <= lrv_pkg::RST_HEADER_SIZE;
        end
        else if (cfg_we)
        begin
            case (lrv_pkg::cfg_idx_t'(cfg_index))
                lrv_pkg::REG_MAX_SEVERITY:    cfg_reg.max_severity      <= cfg_data;
                lrv_pkg::REG_ALLOWED_FLAGS:   cfg_reg.allowed_flag_mask <= cfg_data;
                lrv_pkg::REG_MAX_MESSAGE_LEN: cfg_reg.max_msg_len       <= cfg_data;
                lrv_pkg::REG_MAX_FIELDS_LEN:  cfg_reg.max_fld_len       <= cfg_data;
                lrv_pkg::REG_HEADER_SIZE:
                    cfg_reg.header_size <= cfg_data[lrv_pkg::HSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // header limits are checked as the transfer is captured
    lrv_hdr_check u_hdr_check
    (
        .cfg            (cfg_reg),
        .severity       (s_axis_tdata[31:0]),
        .record_flags   (s_axis_tdata[63:32]),
        .msg_length     (s_axis_tdata[95:64]),
        .fld_length     (s_axis_tdata[127:96]),
        .record_length  (s_axis_tdata[159:128]),
        .hdr_bad        (hdr_bad)
    );

    always_comb
    begin
        item_next.opcode    = lrv_pkg::op_t'(s_axis_tuser);
        item_next.hdr_bad   = hdr_bad;
        item_next.msg_len   = s_axis_tdata[64 +: lrv_pkg::LEN_BITS];
        item_next.fld_len   = s_axis_tdata[96 +: lrv_pkg::LEN_BITS];
        item_next.data_byte = s_axis_tdata[167:160];
        item_next.last      = s_axis_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            item_reg <= item_next;
    end

    // byte checks, record state and verdict
    lrv_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .item           (item_reg),
        .verdict_valid  (verdict_valid),
        .verdict_accept (verdict_accept)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            accept_reg    <= 1'b0;
        end
        else if (verdict_valid)
        begin
            out_valid_reg <= 1'b1;
            accept_reg    <= verdict_accept;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, accept_reg};

endmodule
